@@ sv/fpa_pkg.sv @@
// Shared types and constants of the farthest-pair-across-axis block.
package fpa_pkg;

    localparam int COORD_W   = 16;
    localparam int POINT_W   = 2 * COORD_W;
    localparam int SQ_W      = 32;
    localparam int DIST_W    = 33;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;    // write the accepted point into the store
        logic start;    // clear the pair counters and the running maximum
        logic issue;    // read one pair and advance the pair counters
        logic publish;  // load the result register and clear count and flag
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_pair;  // pair counters sit on the final pair
        logic pipe_busy;  // pairs still in flight in the compare pipeline
        logic out_full;   // result register still holds an untaken result
    } t_sts;

endpackage

@@ sv/fpa_ctrl.sv @@
// Controller state machine: load, pair search and result hand-off.
module fpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  fpa_pkg::t_sts  i_sts,
    output fpa_pkg::t_cmd  o_cmd
);
    import fpa_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign o_in_ready = r_ready;
    assign w_accept   = i_in_valid && r_ready;

    // Decode commands and next state
    always_comb begin
        o_cmd         = '0;
        n_state       = r_state;
        o_cmd.store   = w_accept;
        o_cmd.start   = w_accept && i_in_last;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && i_in_last) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_pair) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy && !i_sts.out_full) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_LOAD);
        end
    end

endmodule

@@ sv/fpa_dp.sv @@
// Datapath: point store, pair counters, distance pipeline and result register.
module fpa_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fpa_pkg::t_cmd                         i_cmd,
    output fpa_pkg::t_sts                         o_sts,
    input  logic [fpa_pkg::POINT_W-1:0]           i_point,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_found,
    output logic                                  o_overflowed,
    output logic signed [fpa_pkg::COORD_W-1:0]    o_right_x,
    output logic signed [fpa_pkg::COORD_W-1:0]    o_right_y,
    output logic signed [fpa_pkg::COORD_W-1:0]    o_left_x,
    output logic signed [fpa_pkg::COORD_W-1:0]    o_left_y,
    output logic [fpa_pkg::DIST_W-1:0]            o_dist_squared
);
    import fpa_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [POINT_W-1:0] r_mem [MAX_POINTS];
    logic [CW-1:0]      r_cnt;
    logic               r_dropped;
    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_j;
    logic [CW-1:0]      w_cnt_m1;
    logic               w_j_end;

    logic [POINT_W-1:0] r_rd_a;
    logic [POINT_W-1:0] r_rd_b;
    logic               r_v1;

    logic signed [COORD_W:0]     w_dx;
    logic signed [COORD_W:0]     w_dy;
    logic signed [2*COORD_W+1:0] w_sqx;
    logic signed [2*COORD_W+1:0] w_sqy;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [POINT_W-1:0] r_p2;
    logic [POINT_W-1:0] r_q2;
    logic               r_ok2;
    logic               r_v2;

    logic [DIST_W-1:0]  w_dist;
    logic [DIST_W-1:0]  r_best;
    logic [POINT_W-1:0] r_bp;
    logic [POINT_W-1:0] r_bq;
    logic               r_have;
    logic               r_out_valid;

    assign w_cnt_m1 = r_cnt - CW'(1);
    assign w_j_end  = (r_j == w_cnt_m1[AW-1:0]);

    assign o_sts.last_pair = w_j_end && (r_i == w_cnt_m1[AW-1:0]);
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_full  = r_out_valid;
    assign o_out_valid     = r_out_valid;

    // Write the store while the count is below capacity
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_cnt < CW'(MAX_POINTS))) begin
            r_mem[r_cnt[AW-1:0]] <= i_point;
        end
    end

    // Read both points of the current pair
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
    end

    // Track fill count and the dropped flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.publish) begin
            r_cnt     <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.store) begin
            if (r_cnt < CW'(MAX_POINTS)) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // Advance pair counters: inner over j, outer over i
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.start) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.issue) begin
            if (w_j_end) begin
                r_j <= '0;
                r_i <= r_i + AW'(1);
            end else begin
                r_j <= r_j + AW'(1);
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // Square the coordinate differences
    assign w_dx  = {r_rd_a[COORD_W-1], r_rd_a[COORD_W-1:0]}
                 - {r_rd_b[COORD_W-1], r_rd_b[COORD_W-1:0]};
    assign w_dy  = {r_rd_a[POINT_W-1], r_rd_a[POINT_W-1:COORD_W]}
                 - {r_rd_b[POINT_W-1], r_rd_b[POINT_W-1:COORD_W]};
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        r_sqx <= w_sqx[SQ_W-1:0];
        r_sqy <= w_sqy[SQ_W-1:0];
        r_p2  <= r_rd_a;
        r_q2  <= r_rd_b;
        // right point has x >= 0, left point has x < 0
        r_ok2 <= !r_rd_a[COORD_W-1] && r_rd_b[COORD_W-1];
    end

    assign w_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Keep the first strictly larger distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_best <= '0;
        end else if (i_cmd.start) begin
            r_have <= 1'b0;
            r_best <= '0;
        end else if (r_v2 && r_ok2 && (w_dist > r_best)) begin
            r_have <= 1'b1;
            r_best <= w_dist;
            r_bp   <= r_p2;
            r_bq   <= r_q2;
        end
    end

    // Result register and its valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_found        <= r_have;
            o_overflowed   <= r_dropped;
            o_right_x      <= r_have ? r_bp[COORD_W-1:0]       : '0;
            o_right_y      <= r_have ? r_bp[POINT_W-1:COORD_W] : '0;
            o_left_x       <= r_have ? r_bq[COORD_W-1:0]       : '0;
            o_left_y       <= r_have ? r_bq[POINT_W-1:COORD_W] : '0;
            o_dist_squared <= r_have ? r_best : '0;
        end
    end

endmodule

@@ sv/farthest_pair_across_axis_core.sv @@
// Points load at one per cycle; after the final point the search issues one pair per
// cycle through the distance pipeline over all count*count (i, j) pairs, then the
// pipeline drains and the result is published once any earlier result has been taken.
// No points are taken from the final point until the result is registered.
// Reset clears the count, flag and handshakes; the point store is not cleared.
module farthest_pair_across_axis_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // coord_x [15:0], coord_y [31:16]
    input  logic [fpa_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // right_x [15:0], right_y [31:16], left_x [47:32], left_y [63:48],
    // dist_squared [96:64], zero fill [103:97]
    output logic [fpa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // found [0], overflowed [1]
    output logic [fpa_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import fpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    logic                      w_found;
    logic                      w_overflowed;
    logic signed [COORD_W-1:0] w_right_x;
    logic signed [COORD_W-1:0] w_right_y;
    logic signed [COORD_W-1:0] w_left_x;
    logic signed [COORD_W-1:0] w_left_y;
    logic [DIST_W-1:0]         w_dist_squared;

    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fpa_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_point        (s_axis_tdata[POINT_W-1:0]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_found        (w_found),
        .o_overflowed   (w_overflowed),
        .o_right_x      (w_right_x),
        .o_right_y      (w_right_y),
        .o_left_x       (w_left_x),
        .o_left_y       (w_left_y),
        .o_dist_squared (w_dist_squared)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {7'b0, w_dist_squared, w_left_y, w_left_x, w_right_y, w_right_x};
    assign m_axis_tuser = {w_overflowed, w_found};

endmodule
